/* rtl/sha_pkg.sv */
// ----------------------------------------------------------------------------
// Sensor average and hysteresis control package
// Shared payload types, register indexes and fixed constants of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha_pkg;

  // Field widths.
  localparam int SAMPLE_W  = 10;
  localparam int RATIO_W   = 10;
  localparam int DUTY_W    = 7;
  localparam int CFG_IDX_W = 3;

  // Q8 ratios: an average is scaled by 256 before it meets base * ratio.
  localparam int Q_SHIFT   = 8;
  localparam int PRD_W     = SAMPLE_W + RATIO_W;

  // Duty mapping: (light - 100) * 100 / (1000 - 100), reduced to (light - 100) / 9.
  localparam int DUTY_OFFSET = 100;
  localparam int DUTY_FULL   = 1000;
  localparam int DUTY_MAX    = 100;
  localparam int DUTY_LOW    = 5;
  localparam int DUTY_HIGH   = 95;
  localparam int DUTY_DIV    = (DUTY_FULL - DUTY_OFFSET) / DUTY_MAX;
  localparam int DUTY_K      = SAMPLE_W + 4;
  localparam int DUTY_RECIP  = ((2 ** DUTY_K) + DUTY_DIV - 1) / DUTY_DIV;
  localparam int DUTY_RCP_W  = $clog2(DUTY_RECIP + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DARK_ON   = 3'd0,
    CFG_DARK_OFF  = 3'd1,
    CFG_WARM      = 3'd2,
    CFG_TOUCH_ON  = 3'd3,
    CFG_TOUCH_OFF = 3'd4
  } cfg_idx_e;

  // Reset values of the ratio registers.
  localparam logic [RATIO_W-1:0] DARK_ON_RST   = 10'd461;
  localparam logic [RATIO_W-1:0] DARK_OFF_RST  = 10'd307;
  localparam logic [RATIO_W-1:0] WARM_RST      = 10'd264;
  localparam logic [RATIO_W-1:0] TOUCH_ON_RST  = 10'd179;
  localparam logic [RATIO_W-1:0] TOUCH_OFF_RST = 10'd230;

  typedef struct packed {
    logic [SAMPLE_W-1:0] light_sample;
    logic [SAMPLE_W-1:0] touch_sample;
    logic [SAMPLE_W-1:0] temp_sample;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] light_avg;
    logic [SAMPLE_W-1:0] touch_avg;
    logic [SAMPLE_W-1:0] temp_avg;
    logic [DUTY_W-1:0]   duty_percent;
    logic                dark_led;
    logic                warm_led;
    logic                touch_led;
  } out_t;

  // One value per channel, used for averages and baselines.
  typedef struct packed {
    logic [SAMPLE_W-1:0] light;
    logic [SAMPLE_W-1:0] touch;
    logic [SAMPLE_W-1:0] temp;
  } chan_t;

  typedef struct packed {
    logic [RATIO_W-1:0] dark_on;
    logic [RATIO_W-1:0] dark_off;
    logic [RATIO_W-1:0] warm;
    logic [RATIO_W-1:0] touch_on;
    logic [RATIO_W-1:0] touch_off;
  } ratios_t;

endpackage

`default_nettype wire

/* rtl/sha_accum.sv */
// ----------------------------------------------------------------------------
// Sample accumulator
// Sums AVG_COUNT sample sets per channel, divides by a reciprocal multiply,
// stores the first average as baseline and forwards every later one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha_accum #(
  parameter int AVG_COUNT = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire sha_pkg::in_t  in_data_i,
  output logic               avg_valid_o,
  input  wire logic          avg_ready_i,
  output sha_pkg::chan_t     avg_o,
  output sha_pkg::chan_t     base_o
);

  localparam int SUM_W   = sha_pkg::SAMPLE_W + $clog2(AVG_COUNT + 1);
  localparam int CNT_W   = $clog2(AVG_COUNT + 1);
  localparam int DIV_K   = SUM_W + $clog2(AVG_COUNT);
  localparam int RECIP_W = DIV_K + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** DIV_K) + AVG_COUNT - 1) / AVG_COUNT);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(AVG_COUNT - 1);

  logic [SUM_W-1:0]  light_sum_q, touch_sum_q, temp_sum_q;
  logic [SUM_W-1:0]  light_tot, touch_tot, temp_tot;
  logic [PROD_W-1:0] light_prod, touch_prod, temp_prod;
  logic [CNT_W-1:0]  cnt_q;
  logic              base_valid_q;
  logic              avg_valid_q;
  sha_pkg::chan_t    avg_q, base_q, avg_new;
  logic              accept, complete;

  assign in_ready_o  = !avg_valid_q || avg_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign complete    = accept && (cnt_q == LAST_CNT);
  assign avg_valid_o = avg_valid_q;
  assign avg_o       = avg_q;
  assign base_o      = base_q;

  // Running totals including the request now at the port.
  assign light_tot = light_sum_q + SUM_W'(in_data_i.light_sample);
  assign touch_tot = touch_sum_q + SUM_W'(in_data_i.touch_sample);
  assign temp_tot  = temp_sum_q + SUM_W'(in_data_i.temp_sample);

  // Division by AVG_COUNT as a rounded-up reciprocal multiply, exact for all sums.
  assign light_prod = PROD_W'(light_tot) * PROD_W'(RECIP);
  assign touch_prod = PROD_W'(touch_tot) * PROD_W'(RECIP);
  assign temp_prod  = PROD_W'(temp_tot) * PROD_W'(RECIP);

  always_comb begin
    avg_new.light = light_prod[DIV_K +: sha_pkg::SAMPLE_W];
    avg_new.touch = touch_prod[DIV_K +: sha_pkg::SAMPLE_W];
    avg_new.temp  = temp_prod[DIV_K +: sha_pkg::SAMPLE_W];
  end

  // Accumulation, baseline capture and the average register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_sum_q  <= '0;
      touch_sum_q  <= '0;
      temp_sum_q   <= '0;
      cnt_q        <= '0;
      base_valid_q <= 1'b0;
      base_q       <= '0;
      avg_valid_q  <= 1'b0;
    end else begin
      if (avg_ready_i) begin
        avg_valid_q <= 1'b0;
      end
      if (complete) begin
        light_sum_q <= '0;
        touch_sum_q <= '0;
        temp_sum_q  <= '0;
        cnt_q       <= '0;
        if (base_valid_q) begin
          avg_valid_q <= 1'b1;
        end else begin
          base_q       <= avg_new;
          base_valid_q <= 1'b1;
        end
      end else if (accept) begin
        light_sum_q <= light_tot;
        touch_sum_q <= touch_tot;
        temp_sum_q  <= temp_tot;
        cnt_q       <= cnt_q + CNT_W'(1);
      end
    end
  end

  // Average payload, loaded only when a result average completes.
  always_ff @(posedge clk_i) begin
    if (complete && base_valid_q) begin
      avg_q <= avg_new;
    end
  end

`ifndef SYNTHESIS
  // The sample counter never runs past the last sample of an average.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= LAST_CNT)
    else $error("sample counter out of range");

  // The first completed average only sets the baseline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (complete && !base_valid_q) |=> (base_valid_q && !$rose(avg_valid_q)))
    else $error("baseline average was forwarded as a result");
`endif

endmodule

`default_nettype wire

/* rtl/sha_eval.sv */
// ----------------------------------------------------------------------------
// Threshold evaluation
// Forms baseline thresholds and the duty quotient, then compares, applies
// LED hysteresis and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha_eval (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             avg_valid_i,
  output logic                  avg_ready_o,
  input  wire sha_pkg::chan_t   avg_i,
  input  wire sha_pkg::chan_t   base_i,
  input  wire sha_pkg::ratios_t ratios_i,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output sha_pkg::out_t         res_o
);

  localparam int PRD_W = sha_pkg::PRD_W;
  localparam int DQ_W  = sha_pkg::SAMPLE_W + sha_pkg::DUTY_RCP_W;

  // Threshold stage registers.
  logic                     s2_valid_q;
  sha_pkg::chan_t           s2_avg_q;
  logic [PRD_W-1:0]         dark_on_q, dark_off_q, warm_q, touch_on_q, touch_off_q;
  logic [sha_pkg::DUTY_W-1:0] quot_q;
  logic                     below_q;

  // Result stage registers.
  logic                     res_valid_q;
  sha_pkg::out_t            res_q;
  logic                     dark_q, touch_q;

  logic                     adv2, adv3, load2;
  logic [sha_pkg::SAMPLE_W-1:0] light_off;
  logic [DQ_W-1:0]          duty_prod;
  logic [PRD_W-1:0]         light_s, touch_s, temp_s;
  logic                     dark_n, warm_n, touch_n;
  logic [sha_pkg::DUTY_W-1:0] duty_n;

  assign adv3        = !res_valid_q || res_ready_i;
  assign adv2        = !s2_valid_q || adv3;
  assign avg_ready_o = adv2;
  assign load2       = avg_valid_i && adv2;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Duty quotient (light - 100) / 9 by reciprocal multiply.
  assign light_off = avg_i.light - sha_pkg::SAMPLE_W'(sha_pkg::DUTY_OFFSET);
  assign duty_prod = DQ_W'(light_off) * DQ_W'(sha_pkg::DUTY_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv2) begin
      s2_valid_q <= avg_valid_i;
    end
  end

  // Baseline times ratio thresholds.
  always_ff @(posedge clk_i) begin
    if (load2) begin
      s2_avg_q    <= avg_i;
      dark_on_q   <= PRD_W'(base_i.light) * PRD_W'(ratios_i.dark_on);
      dark_off_q  <= PRD_W'(base_i.light) * PRD_W'(ratios_i.dark_off);
      warm_q      <= PRD_W'(base_i.temp) * PRD_W'(ratios_i.warm);
      touch_on_q  <= PRD_W'(base_i.touch) * PRD_W'(ratios_i.touch_on);
      touch_off_q <= PRD_W'(base_i.touch) * PRD_W'(ratios_i.touch_off);
      quot_q      <= duty_prod[sha_pkg::DUTY_K +: sha_pkg::DUTY_W];
      below_q     <= avg_i.light < sha_pkg::SAMPLE_W'(sha_pkg::DUTY_OFFSET);
    end
  end

  // Scaled averages for the Q8 comparisons.
  assign light_s = PRD_W'(s2_avg_q.light) << sha_pkg::Q_SHIFT;
  assign touch_s = PRD_W'(s2_avg_q.touch) << sha_pkg::Q_SHIFT;
  assign temp_s  = PRD_W'(s2_avg_q.temp) << sha_pkg::Q_SHIFT;

  // LED decisions: off wins for dark, on wins for touch, dead zone holds.
  always_comb begin
    dark_n = dark_q;
    if (light_s >= dark_on_q) begin
      dark_n = 1'b1;
    end
    if (light_s <= dark_off_q) begin
      dark_n = 1'b0;
    end
    warm_n  = temp_s > warm_q;
    touch_n = touch_q;
    if (touch_s >= touch_off_q) begin
      touch_n = 1'b0;
    end
    if (touch_s <= touch_on_q) begin
      touch_n = 1'b1;
    end
  end

  // Duty clamping near both ends.
  always_comb begin
    if (below_q || quot_q <= sha_pkg::DUTY_W'(sha_pkg::DUTY_LOW)) begin
      duty_n = '0;
    end else if (quot_q >= sha_pkg::DUTY_W'(sha_pkg::DUTY_HIGH)) begin
      duty_n = sha_pkg::DUTY_W'(sha_pkg::DUTY_MAX);
    end else begin
      duty_n = quot_q;
    end
  end

  // LED state and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      dark_q      <= 1'b0;
      touch_q     <= 1'b0;
    end else if (adv3) begin
      res_valid_q <= s2_valid_q;
      if (s2_valid_q) begin
        dark_q  <= dark_n;
        touch_q <= touch_n;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (s2_valid_q && adv3) begin
      res_q.light_avg    <= s2_avg_q.light;
      res_q.touch_avg    <= s2_avg_q.touch;
      res_q.temp_avg     <= s2_avg_q.temp;
      res_q.duty_percent <= duty_n;
      res_q.dark_led     <= dark_n;
      res_q.warm_led     <= warm_n;
      res_q.touch_led    <= touch_n;
    end
  end

`ifndef SYNTHESIS
  // A delivered duty never exceeds full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.duty_percent <= sha_pkg::DUTY_W'(sha_pkg::DUTY_MAX)))
    else $error("duty above full scale");

  // Light at or below the off threshold always turns the dark LED off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && adv3 && light_s <= dark_off_q) |=> !res_q.dark_led)
    else $error("dark LED on below off threshold");

  // Touch at or below the on threshold always turns the touch LED on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && adv3 && touch_s <= touch_on_q) |=> res_q.touch_led)
    else $error("touch LED off below on threshold");

  // The LED state registers follow the last delivered result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (dark_q == res_q.dark_led && touch_q == res_q.touch_led))
    else $error("LED state and result disagree");
`endif

endmodule

`default_nettype wire

/* rtl/sensor_average_hysteresis_control.sv */
// Path: a request that completes an average after the baseline has its result registered in
// the average register, the threshold stage and the result register; other requests give no result.
// Throughput: one request per cycle while out_ready_i does not stall the output, since the
// accumulator, the threshold stage and the result register each take a new item every cycle.
// Reset: asynchronous and active low; sums, counters, baseline and LEDs clear and ratio
// registers return to their defaults.
// ----------------------------------------------------------------------------
// Sensor average and hysteresis control
// Averages three sensor channels, keeps the first average as baseline and
// drives a light duty plus three threshold LEDs from every later average.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sensor_average_hysteresis_control #(
  parameter int AVG_COUNT = 5
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire sha_pkg::in_t                    in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output sha_pkg::out_t                        out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [sha_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [sha_pkg::RATIO_W-1:0]     cfg_data_i
);

  sha_pkg::ratios_t ratios_q;
  sha_pkg::chan_t   avg, base;
  logic             avg_valid, avg_ready;

  assign cfg_ready_o = 1'b1;

  // Ratio registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratios_q.dark_on   <= sha_pkg::DARK_ON_RST;
      ratios_q.dark_off  <= sha_pkg::DARK_OFF_RST;
      ratios_q.warm      <= sha_pkg::WARM_RST;
      ratios_q.touch_on  <= sha_pkg::TOUCH_ON_RST;
      ratios_q.touch_off <= sha_pkg::TOUCH_OFF_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (sha_pkg::cfg_idx_e'(cfg_index_i))
        sha_pkg::CFG_DARK_ON:   ratios_q.dark_on   <= cfg_data_i;
        sha_pkg::CFG_DARK_OFF:  ratios_q.dark_off  <= cfg_data_i;
        sha_pkg::CFG_WARM:      ratios_q.warm      <= cfg_data_i;
        sha_pkg::CFG_TOUCH_ON:  ratios_q.touch_on  <= cfg_data_i;
        sha_pkg::CFG_TOUCH_OFF: ratios_q.touch_off <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Averaging and baseline.
  sha_accum #(
    .AVG_COUNT(AVG_COUNT)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .avg_valid_o (avg_valid),
    .avg_ready_i (avg_ready),
    .avg_o       (avg),
    .base_o      (base)
  );

  // Thresholds, hysteresis and result register.
  sha_eval u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avg_valid_i (avg_valid),
    .avg_ready_o (avg_ready),
    .avg_i       (avg),
    .base_i      (base),
    .ratios_i    (ratios_q),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (out_data_o)
  );

endmodule

`default_nettype wire

/* tb/sv/sensor_average_hysteresis_control_tb.sv */
// ----------------------------------------------------------------------------
// Sensor average and hysteresis control testbench
// Drives sample sets through the block with random pacing on both channels,
// predicts every report from its own copy of the averaging and LED state, and
// compares each report field by field as it leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_average_hysteresis_control_tb;

  import sha_pkg::*;

  localparam int SET_SIZE         = 5;
  localparam int RESET_CYCLES     = 12;
  localparam int SETTLE_CYCLES    = 8;
  localparam int TAIL_CYCLES      = 16;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int REPORT_LIMIT     = 10;
  localparam int RANDOM_PHASES    = 8;
  localparam int SETS_PER_PHASE   = 36;
  localparam int CROSSED_SETS     = 10;
  localparam int MAX_SAMPLE       = (1 << SAMPLE_W) - 1;

  // Block ports.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_t                  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_t                 out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [RATIO_W-1:0]   cfg_data_i  = '0;

  // Pacing controls shared by the sender and the report sink.
  bit src_gaps_en    = 1'b1;
  bit sink_stalls_en = 1'b1;

  // Predicted block state.
  int unsigned light_acc      = 0;
  int unsigned touch_acc      = 0;
  int unsigned temp_acc       = 0;
  int unsigned samples_in_set = 0;
  bit          have_baseline  = 1'b0;
  chan_t       baseline       = '0;
  bit          led_dark       = 1'b0;
  bit          led_warm       = 1'b0;
  bit          led_touch      = 1'b0;
  ratios_t     ratio_regs     = '{dark_on: DARK_ON_RST, dark_off: DARK_OFF_RST,
                                  warm: WARM_RST, touch_on: TOUCH_ON_RST,
                                  touch_off: TOUCH_OFF_RST};

  out_t expected_reports [$];
  int   error_count = 0;

  sensor_average_hysteresis_control #(
    .AVG_COUNT(SET_SIZE)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock generation.
  always #6 clk_i = ~clk_i;

  // Counts an error and prints the first few of them.
  task automatic log_error(string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      log_error($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
    end
  endtask

  // Idle gap length: mostly none or short, now and then long.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Adds random spread to a target sample and clamps it to the field range.
  function automatic logic [SAMPLE_W-1:0] jitter(int target, int spread);
    int v;
    v = target + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > MAX_SAMPLE) v = MAX_SAMPLE;
    return v[SAMPLE_W-1:0];
  endfunction

  // Accumulates one sample set and, on the last sample of an average,
  // stores the baseline or queues the report the block should produce.
  task automatic predict_sample_set(in_t s);
    int unsigned la, ta, ea, lb, tb, eb;
    int          q;
    bit          dark, tch;
    out_t        rep;
    light_acc += s.light_sample;
    touch_acc += s.touch_sample;
    temp_acc  += s.temp_sample;
    samples_in_set++;
    if (samples_in_set < SET_SIZE) return;

    la = light_acc / SET_SIZE;
    ta = touch_acc / SET_SIZE;
    ea = temp_acc / SET_SIZE;
    light_acc = 0;
    touch_acc = 0;
    temp_acc = 0;
    samples_in_set = 0;

    if (!have_baseline) begin
      baseline = '{light: la[SAMPLE_W-1:0], touch: ta[SAMPLE_W-1:0],
                   temp: ea[SAMPLE_W-1:0]};
      have_baseline = 1'b1;
      return;
    end

    lb = baseline.light;
    tb = baseline.touch;
    eb = baseline.temp;

    // Dark LED: off wins when both thresholds are met.
    dark = led_dark;
    if ((la << Q_SHIFT) >= lb * ratio_regs.dark_on) dark = 1'b1;
    if ((la << Q_SHIFT) <= lb * ratio_regs.dark_off) dark = 1'b0;

    led_warm = (ea << Q_SHIFT) > eb * ratio_regs.warm;

    // Touch LED: on wins when both thresholds are met.
    tch = led_touch;
    if ((ta << Q_SHIFT) >= tb * ratio_regs.touch_off) tch = 1'b0;
    if ((ta << Q_SHIFT) <= tb * ratio_regs.touch_on) tch = 1'b1;

    led_dark = dark;
    led_touch = tch;

    // Duty from signed, truncating arithmetic, clamped near both ends.
    q = ((int'(la) - DUTY_OFFSET) * DUTY_MAX) / (DUTY_FULL - DUTY_OFFSET);
    if (q <= DUTY_LOW) q = 0;
    else if (q >= DUTY_HIGH) q = DUTY_MAX;

    rep.light_avg    = la[SAMPLE_W-1:0];
    rep.touch_avg    = ta[SAMPLE_W-1:0];
    rep.temp_avg     = ea[SAMPLE_W-1:0];
    rep.duty_percent = q[DUTY_W-1:0];
    rep.dark_led     = led_dark;
    rep.warm_led     = led_warm;
    rep.touch_led    = led_touch;
    expected_reports.push_back(rep);
  endtask

  // Sends one request; valid is only lowered when a gap precedes it.
  task automatic send_sample(in_t s);
    int gap;
    gap = src_gaps_en ? pick_pause() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (!in_ready_o);
    predict_sample_set(s);
  endtask

  // One full averaging set around the given targets.
  task automatic send_set(int light, int touch, int temp, int spread);
    in_t s;
    for (int i = 0; i < SET_SIZE; i++) begin
      s.light_sample = jitter(light, spread);
      s.touch_sample = jitter(touch, spread);
      s.temp_sample  = jitter(temp, spread);
      send_sample(s);
    end
  endtask

  // Stops the sender, waits for every pending report, then lets the
  // pipeline settle so no set in flight can see a register change.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write; valid stays high so writes can follow back to back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATIO_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DARK_ON:   ratio_regs.dark_on   = val;
      CFG_DARK_OFF:  ratio_regs.dark_off  = val;
      CFG_WARM:      ratio_regs.warm      = val;
      CFG_TOUCH_ON:  ratio_regs.touch_on  = val;
      CFG_TOUCH_OFF: ratio_regs.touch_off = val;
      default: ;
    endcase
  endtask

  task automatic program_ratios(ratios_t r);
    write_reg(CFG_DARK_ON, r.dark_on);
    write_reg(CFG_DARK_OFF, r.dark_off);
    write_reg(CFG_WARM, r.warm);
    write_reg(CFG_TOUCH_ON, r.touch_on);
    write_reg(CFG_TOUCH_OFF, r.touch_off);
    cfg_valid_i <= 1'b0;
  endtask

  // Picks an average to aim at: anywhere, at either threshold, at the
  // field extremes, or at the duty clamp boundaries.
  function automatic int pick_target(int unsigned base, int unsigned ratio_a,
                                     int unsigned ratio_b);
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, MAX_SAMPLE);
      1: return int'((base * ratio_a) >> Q_SHIFT) + int'($urandom_range(0, 4)) - 2;
      2: return int'((base * ratio_b) >> Q_SHIFT) + int'($urandom_range(0, 4)) - 2;
      3: return $urandom_range(0, 1) ? $urandom_range(0, 8)
                                     : $urandom_range(MAX_SAMPLE - 8, MAX_SAMPLE);
      default: begin
        case ($urandom_range(0, 3))
          0: return 153;
          1: return 154;
          2: return 954;
          default: return 955;
        endcase
      end
    endcase
  endfunction

  // Mostly well-formed sets aimed at interesting averages, some pure noise.
  task automatic send_random_set();
    in_t s;
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < SET_SIZE; i++) begin
        s.light_sample = $urandom_range(0, MAX_SAMPLE);
        s.touch_sample = $urandom_range(0, MAX_SAMPLE);
        s.temp_sample  = $urandom_range(0, MAX_SAMPLE);
        send_sample(s);
      end
    end else begin
      send_set(pick_target(baseline.light, ratio_regs.dark_on, ratio_regs.dark_off),
               pick_target(baseline.touch, ratio_regs.touch_on, ratio_regs.touch_off),
               pick_target(baseline.temp, ratio_regs.warm, ratio_regs.warm),
               $urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
    end
  endtask

  // The first average only sets the baseline; its samples include both
  // field extremes while the averages land mid-range.
  task automatic test_baseline();
    logic [SAMPLE_W-1:0] light_set [SET_SIZE] = '{1023, 0, 300, 450, 512};
    logic [SAMPLE_W-1:0] touch_set [SET_SIZE] = '{0, 1023, 600, 520, 400};
    logic [SAMPLE_W-1:0] temp_set  [SET_SIZE] = '{512, 1023, 0, 200, 300};
    in_t s;
    for (int i = 0; i < SET_SIZE; i++) begin
      s = '{light_sample: light_set[i], touch_sample: touch_set[i],
            temp_sample: temp_set[i]};
      send_sample(s);
    end
    wait_idle();
  endtask

  // All-max and all-zero sets: full duty, empty duty, both LED extremes.
  task automatic test_field_extremes();
    send_set(MAX_SAMPLE, MAX_SAMPLE, MAX_SAMPLE, 0);
    send_set(0, 0, 0, 0);
  endtask

  // Averages between the on and off thresholds must hold the LED state,
  // tried from both LED states; temperature straddles its threshold.
  task automatic test_dead_zone();
    int light_mid, touch_mid, warm_bound;
    light_mid  = (baseline.light * (ratio_regs.dark_on + ratio_regs.dark_off)) >> 9;
    touch_mid  = (baseline.touch * (ratio_regs.touch_on + ratio_regs.touch_off)) >> 9;
    warm_bound = (baseline.temp * ratio_regs.warm) >> Q_SHIFT;
    send_set(light_mid, touch_mid, warm_bound + 1, 0);
    send_set(MAX_SAMPLE, MAX_SAMPLE, warm_bound, 0);
    send_set(light_mid, touch_mid, warm_bound + 1, 0);
    wait_idle();
  endtask

  // Writes to indexes beyond the last register must change nothing.
  task automatic test_unknown_index();
    for (int i = int'(CFG_TOUCH_OFF) + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), $urandom_range(0, (1 << RATIO_W) - 1));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Crossed ratios make both conditions true in the overlap: dark off wins,
  // touch on wins.
  task automatic test_crossed_ratios();
    ratios_t r;
    r = '{dark_on: 10'd200, dark_off: 10'd400, warm: $urandom_range(0, 1023),
          touch_on: 10'd400, touch_off: 10'd200};
    program_ratios(r);
    for (int i = 0; i < CROSSED_SETS; i++) send_random_set();
    wait_idle();
  endtask

  // Random traffic over several register settings, extremes first.
  task automatic test_random_traffic();
    ratios_t r;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: r = '0;
        1: r = '1;
        2: r = '{dark_on: DARK_ON_RST, dark_off: DARK_OFF_RST, warm: WARM_RST,
                 touch_on: TOUCH_ON_RST, touch_off: TOUCH_OFF_RST};
        default: r = '{dark_on: $urandom_range(0, 1023), dark_off: $urandom_range(0, 1023),
                       warm: $urandom_range(0, 1023), touch_on: $urandom_range(0, 1023),
                       touch_off: $urandom_range(0, 1023)};
      endcase
      program_ratios(r);
      src_gaps_en    = $urandom_range(0, 3) != 0;
      sink_stalls_en = $urandom_range(0, 3) != 0;
      for (int i = 0; i < SETS_PER_PHASE; i++) begin
        // Occasionally flip the pacing to get stretches with and without gaps.
        if ($urandom_range(0, 11) == 0) src_gaps_en = !src_gaps_en;
        if ($urandom_range(0, 11) == 0) sink_stalls_en = !sink_stalls_en;
        send_random_set();
      end
      wait_idle();
    end
  endtask

  // Report sink pacing: random stalls of mostly short length.
  initial begin : sink_pacing
    int hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (sink_stalls_en && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        hold = pick_pause();
      end else begin
        out_ready_i <= 1'b1;
        hold = $urandom_range(0, 5);
      end
    end
  end

  // Each accepted report is checked against the oldest prediction.
  always @(posedge clk_i) begin : check_reports
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        log_error($sformatf("report with none pending: light_avg %0d",
                            out_data_o.light_avg));
      end else begin
        want = expected_reports.pop_front();
        compare_field("light_avg", want.light_avg, out_data_o.light_avg);
        compare_field("touch_avg", want.touch_avg, out_data_o.touch_avg);
        compare_field("temp_avg", want.temp_avg, out_data_o.temp_avg);
        compare_field("duty_percent", want.duty_percent, out_data_o.duty_percent);
        compare_field("dark_led", want.dark_led, out_data_o.dark_led);
        compare_field("warm_led", want.warm_led, out_data_o.warm_led);
        compare_field("touch_led", want.touch_led, out_data_o.touch_led);
      end
    end
  end

  // Watchdog: ends the run when no request moves for too long.
  initial begin : watchdog
    int idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_baseline();
    test_field_extremes();
    test_dead_zone();
    test_unknown_index();
    test_crossed_ratios();
    test_random_traffic();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      log_error($sformatf("%0d reports never arrived", expected_reports.size()));
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
